[rtl/multi_reader_ring_buffer_assert.svh]
// ----------------------------------------------------------------------------
// multi reader ring buffer assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef MULTI_READER_RING_BUFFER_ASSERT_SVH
`define MULTI_READER_RING_BUFFER_ASSERT_SVH

`ifndef ASSERT_OFF
`define MRRB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MRRB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MRRB_ASSERT(lbl, clk, rst_n, prop, msg)
`define MRRB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/mrrb_pkg.sv]
// ----------------------------------------------------------------------------
// mrrb_pkg
// shared codes, state type and memory control struct of the broadcast ring
// ----------------------------------------------------------------------------
package mrrb_pkg;

    localparam int OP_W   = 3;
    localparam int ID_W   = 16;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE    = 3'd0,
        OP_READ     = 3'd1,
        OP_FLUSH    = 3'd2,
        OP_FORK     = 3'd3,
        OP_CLOSE_RD = 3'd4,
        OP_CLOSE_WR = 3'd5,
        OP_CREATE   = 3'd6,
        OP_NONE     = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_CLOSED  = 3'd1,
        STS_UNKNOWN = 3'd2,
        STS_FULL    = 3'd3,
        STS_NOTHING = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_EXEC,
        S_RD_ISSUE,
        S_RD_EMIT,
        S_FLUSH,
        S_FLUSH_END,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

[rtl/mrrb_ring_mem.sv]
// ----------------------------------------------------------------------------
// mrrb_ring_mem
// byte ring storage, one write and one registered read port
// ----------------------------------------------------------------------------
module mrrb_ring_mem #(
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  mrrb_pkg::t_mem_ctl           i_ctl,
    input  logic [AW-1:0]                i_waddr,
    input  logic [mrrb_pkg::BYTE_W-1:0]  i_wdata,
    input  logic [AW-1:0]                i_raddr,
    output logic [mrrb_pkg::BYTE_W-1:0]  o_rdata
);

    logic [mrrb_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [mrrb_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mrrb_slot_mem.sv]
// ----------------------------------------------------------------------------
// mrrb_slot_mem
// slot table storage: owner id and read pointer per slot
// ----------------------------------------------------------------------------
module mrrb_slot_mem #(
    parameter int DEPTH = 8,
    parameter int PW = 12,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  mrrb_pkg::t_mem_ctl         i_ctl,
    input  logic [AW-1:0]              i_waddr,
    input  logic [mrrb_pkg::ID_W-1:0]  i_wowner,
    input  logic [PW-1:0]              i_wrp,
    input  logic [AW-1:0]              i_raddr,
    output logic [mrrb_pkg::ID_W-1:0]  o_rowner,
    output logic [PW-1:0]              o_rrp
);

    logic [mrrb_pkg::ID_W+PW-1:0] mem [DEPTH];
    logic [mrrb_pkg::ID_W+PW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_waddr] <= {i_wowner, i_wrp};
        end
        if (i_ctl.rd_en) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rowner = r_rdata[mrrb_pkg::ID_W+PW-1:PW];
    assign o_rrp    = r_rdata[PW-1:0];

endmodule

[rtl/multi_reader_ring_buffer.sv]
// ----------------------------------------------------------------------------
// multi_reader_ring_buffer
// broadcast byte ring with per-process read pointers held in a slot table
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// request   in         i_valid / o_ready    i_opcode i_process_id i_child_id
//                                           i_write_byte i_byte_count
// result    out        o_valid / i_ready    o_status o_read_byte o_byte_valid
//                                           o_reclaimed_count o_pipe_released o_last
//
// one item at a time, taken in the idle cycle. lookup walks the slot memory one
// slot a cycle, then comes the execute state; an unknown process goes straight
// from lookup to the result state, and create and none skip lookup. flush walks
// the whole table before the result state. a read with bytes issues each on the
// ring memory's registered read port and then emits it, with no result state.
// reset needs no clearing pass; a stalled result holds the block.
// ----------------------------------------------------------------------------
`include "multi_reader_ring_buffer_assert.svh"

module multi_reader_ring_buffer #(
    parameter int RING_BYTES     = 4096,
    parameter int SLOT_COUNT     = 8,
    parameter int MAX_READ_BURST = 64,
    localparam int OCCW = $clog2(RING_BYTES + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [mrrb_pkg::OP_W-1:0]         i_opcode,
    input  logic [mrrb_pkg::ID_W-1:0]         i_process_id,
    input  logic [mrrb_pkg::ID_W-1:0]         i_child_id,
    input  logic [mrrb_pkg::BYTE_W-1:0]       i_write_byte,
    input  logic [mrrb_pkg::CNT_W-1:0]        i_byte_count,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [2:0]                        o_status,
    output logic [mrrb_pkg::BYTE_W-1:0]       o_read_byte,
    output logic                              o_byte_valid,
    output logic [OCCW-1:0]                   o_reclaimed_count,
    output logic                              o_pipe_released,
    output logic                              o_last
);

    localparam int PTRW = $clog2(RING_BYTES);
    localparam int SW   = $clog2(SLOT_COUNT);
    localparam int ACTW = $clog2(SLOT_COUNT + 1);
    localparam int MW   = (OCCW > mrrb_pkg::CNT_W) ? OCCW : mrrb_pkg::CNT_W;
    localparam logic [PTRW-1:0] LAST_POS = PTRW'(RING_BYTES - 1);
    localparam logic [OCCW-1:0] RING_FULL = OCCW'(RING_BYTES);

    mrrb_pkg::t_state  r_state, n_state;
    mrrb_pkg::t_op     r_op;
    mrrb_pkg::t_status r_res_status;
    logic [mrrb_pkg::ID_W-1:0]   r_pid, r_child, r_sown;
    logic [mrrb_pkg::BYTE_W-1:0] r_wb;
    logic [mrrb_pkg::CNT_W-1:0]  r_cnt, r_n;
    logic [PTRW-1:0]             r_wp, r_srp, r_rp;
    logic [OCCW-1:0]             r_occ, r_min, r_res_freed;
    logic [ACTW-1:0]             r_active;
    logic [SLOT_COUNT-1:0]       r_in_use, r_rd, r_wr, r_caught;
    logic [SW:0]                 r_idx;
    logic                        r_pend;
    logic [SW-1:0]               r_pidx, r_s;
    logic                        r_res_rel;

    logic                        r_ov, r_o_bv, r_o_rel, r_o_last;
    logic [2:0]                  r_o_status;
    logic [mrrb_pkg::BYTE_W-1:0] r_o_byte;
    logic [OCCW-1:0]             r_o_freed;

    mrrb_pkg::t_mem_ctl          ring_ctl, slot_ctl;
    logic [mrrb_pkg::BYTE_W-1:0] ring_rdata;
    logic [SW-1:0]               slot_waddr;
    logic [mrrb_pkg::ID_W-1:0]   slot_wowner, slot_rowner;
    logic [PTRW-1:0]             slot_wrp, slot_rrp;

    logic                        can_push, accept, idx_live, lk_hit, scan_done;
    logic                        wr_ok, fork_ok, free_found, rd_last;
    logic [SW-1:0]               free_idx;
    logic [OCCW-1:0]             unread_s, unread_p, used_p;
    logic [MW-1:0]               burst_len;
    logic [PTRW-1:0]             rp_next;

    function automatic logic [PTRW-1:0] f_next(input logic [PTRW-1:0] p);
        return (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

    // bytes a reader at rp has not yet seen
    function automatic logic [OCCW-1:0] f_unread(input logic [PTRW-1:0] rp,
                                                 input logic caught,
                                                 input logic [PTRW-1:0] wp,
                                                 input logic [OCCW-1:0] occ);
        logic [OCCW-1:0] d;
        if (wp >= rp) begin
            d = OCCW'(wp) - OCCW'(rp);
        end else begin
            d = OCCW'(wp) + RING_FULL - OCCW'(rp);
        end
        if (d == '0) begin
            d = (occ >= RING_FULL && !caught) ? occ : '0;
        end
        if (d > occ) begin
            d = occ;
        end
        return d;
    endfunction

    assign can_push  = !r_ov || i_ready;
    assign accept    = i_valid && o_ready;
    assign idx_live  = r_idx < (SW+1)'(SLOT_COUNT);
    assign lk_hit    = r_pend && r_in_use[r_pidx] && (slot_rowner == r_pid);
    assign scan_done = r_pend && (r_pidx == SW'(SLOT_COUNT - 1));
    assign unread_s  = f_unread(r_srp, r_caught[r_s], r_wp, r_occ);
    assign unread_p  = f_unread(slot_rrp, r_caught[r_pidx], r_wp, r_occ);
    assign used_p    = r_occ - unread_p;
    assign wr_ok     = r_wr[r_s] && (r_occ < RING_FULL);
    assign fork_ok   = free_found && (r_active < ACTW'(SLOT_COUNT));
    assign rp_next   = f_next(r_rp);
    assign rd_last   = (r_n == mrrb_pkg::CNT_W'(1));

    always_comb begin
        logic [MW-1:0] a;
        a = MW'(unread_s);
        if (MW'(r_cnt) < a) begin
            a = MW'(r_cnt);
        end
        if (MW'(MAX_READ_BURST) < a) begin
            a = MW'(MAX_READ_BURST);
        end
        burst_len = a;
    end

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mrrb_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_opcode == mrrb_pkg::OP_CREATE || i_opcode == mrrb_pkg::OP_NONE) begin
                        n_state = mrrb_pkg::S_EXEC;
                    end else begin
                        n_state = mrrb_pkg::S_LOOKUP;
                    end
                end
            end
            mrrb_pkg::S_LOOKUP: begin
                if (lk_hit) begin
                    n_state = mrrb_pkg::S_EXEC;
                end else if (scan_done) begin
                    n_state = mrrb_pkg::S_RESULT;
                end
            end
            mrrb_pkg::S_EXEC: begin
                n_state = mrrb_pkg::S_RESULT;
                if (r_op == mrrb_pkg::OP_FLUSH) begin
                    n_state = mrrb_pkg::S_FLUSH;
                end else if (r_op == mrrb_pkg::OP_READ && r_rd[r_s] && burst_len != '0) begin
                    n_state = mrrb_pkg::S_RD_ISSUE;
                end
            end
            mrrb_pkg::S_RD_ISSUE: n_state = mrrb_pkg::S_RD_EMIT;
            mrrb_pkg::S_RD_EMIT: begin
                if (can_push) begin
                    n_state = rd_last ? mrrb_pkg::S_IDLE : mrrb_pkg::S_RD_ISSUE;
                end
            end
            mrrb_pkg::S_FLUSH: begin
                if (scan_done) begin
                    n_state = mrrb_pkg::S_FLUSH_END;
                end
            end
            mrrb_pkg::S_FLUSH_END: n_state = mrrb_pkg::S_RESULT;
            mrrb_pkg::S_RESULT: begin
                if (can_push) begin
                    n_state = mrrb_pkg::S_IDLE;
                end
            end
            default: n_state = mrrb_pkg::S_IDLE;
        endcase
    end

    // memory control and handshake
    always_comb begin
        o_ready        = (r_state == mrrb_pkg::S_IDLE);
        ring_ctl.wr_en = (r_state == mrrb_pkg::S_EXEC) && (r_op == mrrb_pkg::OP_WRITE)
                         && wr_ok;
        ring_ctl.rd_en = (r_state == mrrb_pkg::S_RD_ISSUE);
        slot_ctl.rd_en = (r_state == mrrb_pkg::S_LOOKUP || r_state == mrrb_pkg::S_FLUSH)
                         && idx_live;
        slot_ctl.wr_en = 1'b0;
        slot_waddr     = r_s;
        slot_wowner    = r_sown;
        slot_wrp       = rp_next;
        case (r_state)
            mrrb_pkg::S_EXEC: begin
                if (r_op == mrrb_pkg::OP_FORK) begin
                    slot_ctl.wr_en = fork_ok;
                    slot_waddr     = free_idx;
                    slot_wowner    = r_child;
                    slot_wrp       = r_srp;
                end else if (r_op == mrrb_pkg::OP_CREATE) begin
                    slot_ctl.wr_en = 1'b1;
                    slot_waddr     = '0;
                    slot_wowner    = r_pid;
                    slot_wrp       = '0;
                end
            end
            mrrb_pkg::S_RD_EMIT: slot_ctl.wr_en = can_push && rd_last;
            default: slot_ctl.wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mrrb_pkg::S_IDLE;
            r_wp     <= '0;
            r_occ    <= '0;
            r_active <= '0;
            r_in_use <= '0;
            r_rd     <= '0;
            r_wr     <= '0;
            r_caught <= '0;
            r_pend   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (can_push) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                mrrb_pkg::S_IDLE: begin
                    if (accept) begin
                        r_op    <= mrrb_pkg::t_op'(i_opcode);
                        r_pid   <= i_process_id;
                        r_child <= i_child_id;
                        r_wb    <= i_write_byte;
                        r_cnt   <= i_byte_count;
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                    end
                end
                mrrb_pkg::S_LOOKUP: begin
                    r_pend  <= idx_live;
                    r_pidx  <= r_idx[SW-1:0];
                    if (idx_live) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (lk_hit) begin
                        r_s    <= r_pidx;
                        r_srp  <= slot_rrp;
                        r_sown <= slot_rowner;
                    end else if (scan_done) begin
                        r_res_status <= mrrb_pkg::STS_UNKNOWN;
                        r_res_freed  <= '0;
                        r_res_rel    <= 1'b0;
                    end
                end
                mrrb_pkg::S_EXEC: begin
                    r_res_status <= mrrb_pkg::STS_OK;
                    r_res_freed  <= '0;
                    r_res_rel    <= 1'b0;
                    case (r_op)
                        mrrb_pkg::OP_WRITE: begin
                            if (!r_wr[r_s]) begin
                                r_res_status <= mrrb_pkg::STS_CLOSED;
                            end else if (!wr_ok) begin
                                r_res_status <= mrrb_pkg::STS_NOTHING;
                            end else begin
                                r_wp     <= f_next(r_wp);
                                r_occ    <= r_occ + 1'b1;
                                r_caught <= '0;
                            end
                        end
                        mrrb_pkg::OP_READ: begin
                            if (!r_rd[r_s]) begin
                                r_res_status <= mrrb_pkg::STS_CLOSED;
                            end else if (burst_len == '0) begin
                                r_res_status <= mrrb_pkg::STS_NOTHING;
                            end
                            r_n  <= mrrb_pkg::CNT_W'(burst_len);
                            r_rp <= r_srp;
                        end
                        mrrb_pkg::OP_FLUSH: begin
                            r_min  <= r_occ;
                            r_idx  <= '0;
                            r_pend <= 1'b0;
                        end
                        mrrb_pkg::OP_FORK: begin
                            if (!fork_ok) begin
                                r_res_status <= mrrb_pkg::STS_FULL;
                            end else begin
                                r_in_use[free_idx] <= 1'b1;
                                r_rd[free_idx]     <= r_rd[r_s];
                                r_wr[free_idx]     <= r_wr[r_s];
                                r_caught[free_idx] <= r_caught[r_s];
                                r_active           <= r_active + 1'b1;
                            end
                        end
                        mrrb_pkg::OP_CLOSE_RD, mrrb_pkg::OP_CLOSE_WR: begin
                            if ((r_op == mrrb_pkg::OP_CLOSE_RD) ? !r_rd[r_s] : !r_wr[r_s]) begin
                                r_res_status <= mrrb_pkg::STS_CLOSED;
                            end else begin
                                if (r_op == mrrb_pkg::OP_CLOSE_RD) begin
                                    r_rd[r_s] <= 1'b0;
                                end else begin
                                    r_wr[r_s] <= 1'b0;
                                end
                                // other end already closed: the slot goes
                                if ((r_op == mrrb_pkg::OP_CLOSE_RD) ? !r_wr[r_s] : !r_rd[r_s]) begin
                                    r_in_use[r_s] <= 1'b0;
                                    r_caught[r_s] <= 1'b0;
                                    r_active      <= r_active - 1'b1;
                                    if (r_active == ACTW'(1)) begin
                                        r_wp      <= '0;
                                        r_occ     <= '0;
                                        r_in_use  <= '0;
                                        r_rd      <= '0;
                                        r_wr      <= '0;
                                        r_caught  <= '0;
                                        r_active  <= '0;
                                        r_res_rel <= 1'b1;
                                    end
                                end
                            end
                        end
                        mrrb_pkg::OP_CREATE: begin
                            r_wp     <= '0;
                            r_occ    <= '0;
                            r_active <= ACTW'(1);
                            r_in_use <= SLOT_COUNT'(1);
                            r_rd     <= SLOT_COUNT'(1);
                            r_wr     <= SLOT_COUNT'(1);
                            r_caught <= '0;
                        end
                        default: r_res_status <= mrrb_pkg::STS_NOTHING;
                    endcase
                end
                mrrb_pkg::S_RD_EMIT: begin
                    if (can_push) begin
                        r_ov       <= 1'b1;
                        r_o_status <= mrrb_pkg::STS_OK;
                        r_o_byte   <= ring_rdata;
                        r_o_bv     <= 1'b1;
                        r_o_freed  <= '0;
                        r_o_rel    <= 1'b0;
                        r_o_last   <= rd_last;
                        r_rp       <= rp_next;
                        r_n        <= r_n - 1'b1;
                        if (rd_last) begin
                            r_caught[r_s] <= (rp_next == r_wp);
                        end
                    end
                end
                mrrb_pkg::S_FLUSH: begin
                    r_pend <= idx_live;
                    r_pidx <= r_idx[SW-1:0];
                    if (idx_live) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_pend && r_in_use[r_pidx] && r_rd[r_pidx] && used_p < r_min) begin
                        r_min <= used_p;
                    end
                end
                mrrb_pkg::S_FLUSH_END: begin
                    r_occ        <= r_occ - r_min;
                    r_res_freed  <= r_min;
                    r_res_status <= mrrb_pkg::STS_OK;
                    r_res_rel    <= 1'b0;
                    if (r_min != '0) begin
                        r_caught <= '0;
                    end
                end
                mrrb_pkg::S_RESULT: begin
                    if (can_push) begin
                        r_ov       <= 1'b1;
                        r_o_status <= r_res_status;
                        r_o_byte   <= '0;
                        r_o_bv     <= 1'b0;
                        r_o_freed  <= r_res_freed;
                        r_o_rel    <= r_res_rel;
                        r_o_last   <= 1'b1;
                    end
                end
                default: r_pend <= 1'b0;
            endcase
        end
    end

    mrrb_ring_mem #(
        .DEPTH (RING_BYTES)
    ) u_ring (
        .i_clk   (i_clk),
        .i_ctl   (ring_ctl),
        .i_waddr (r_wp),
        .i_wdata (r_wb),
        .i_raddr (r_rp),
        .o_rdata (ring_rdata)
    );

    mrrb_slot_mem #(
        .DEPTH (SLOT_COUNT),
        .PW    (PTRW)
    ) u_slot (
        .i_clk    (i_clk),
        .i_ctl    (slot_ctl),
        .i_waddr  (slot_waddr),
        .i_wowner (slot_wowner),
        .i_wrp    (slot_wrp),
        .i_raddr  (r_idx[SW-1:0]),
        .o_rowner (slot_rowner),
        .o_rrp    (slot_rrp)
    );

    assign o_valid           = r_ov;
    assign o_status          = r_o_status;
    assign o_read_byte       = r_o_byte;
    assign o_byte_valid      = r_o_bv;
    assign o_reclaimed_count = r_o_freed;
    assign o_pipe_released   = r_o_rel;
    assign o_last            = r_o_last;

    `MRRB_ASSERT(a_occ_bound, i_clk, i_rst_n, r_occ <= RING_FULL, "occupancy above ring size")
    `MRRB_ASSERT(a_active_count, i_clk, i_rst_n, r_active == ACTW'($countones(r_in_use)), "active count and slot use disagree")
    `MRRB_ASSERT(a_free_slot_flags, i_clk, i_rst_n, ((r_rd | r_wr | r_caught) & ~r_in_use) == '0, "free slot holds flags")
    `MRRB_ASSERT(a_busy_after_accept, i_clk, i_rst_n, accept |=> r_state != mrrb_pkg::S_IDLE, "accepted item left no work")

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: multi reader ring buffer testbench
// drives opcodes through the request channel from a queue, predicts every
// result item from a shadow copy of the ring and slot table, and checks the
// result channel in order under random idling and a long receiver hold-off
// ----------------------------------------------------------------------------
module tb;

    localparam int RING  = 4096;
    localparam int SLOTS = 8;
    localparam int BURST = 64;

    typedef struct {
        mrrb_pkg::t_op op;
        logic [15:0]   pid;
        logic [15:0]   child;
        logic [7:0]    wbyte;
        logic [6:0]    cnt;
    } t_req;

    typedef struct {
        mrrb_pkg::t_status status;
        logic [7:0]        rbyte;
        logic              bvalid;
        logic [12:0]       freed;
        logic              released;
        logic              last;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_opcode = '0;
    logic [15:0] i_process_id = '0;
    logic [15:0] i_child_id = '0;
    logic [7:0]  i_write_byte = '0;
    logic [6:0]  i_byte_count = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [7:0]  o_read_byte;
    logic        o_byte_valid;
    logic [12:0] o_reclaimed_count;
    logic        o_pipe_released;
    logic        o_last;

    multi_reader_ring_buffer dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_req pending_reqs[$];
    t_res expected_results[$];
    int   errors = 0;
    int   reqs_taken = 0;
    int   results_seen = 0;

    // shadow state of the pipe
    logic [7:0] ring_mem[RING];
    int         wr_ptr, rc_ptr, held, live_slots;
    logic       used[SLOTS];
    logic [15:0] owner[SLOTS];
    logic [2:0] flags[SLOTS];  // bit 0 read open, bit 1 write open, bit 2 caught up
    int         rd_ptr[SLOTS];

    function automatic void wipe_pipe();
        wr_ptr = 0; rc_ptr = 0; held = 0; live_slots = 0;
        for (int i = 0; i < SLOTS; i++) begin
            used[i] = 1'b0; owner[i] = '0; flags[i] = '0; rd_ptr[i] = 0;
        end
    endfunction

    function automatic int unread(int s);
        int d;
        d = (wr_ptr + RING - rd_ptr[s]) % RING;
        if (d == 0)
            d = (held >= RING && !flags[s][2]) ? held : 0;
        if (d > held) d = held;
        return d;
    endfunction

    function automatic void push_result(mrrb_pkg::t_status st, logic [7:0] b, logic bv,
                                        int fr, logic rel, logic lst);
        t_res r;
        r.status = st; r.rbyte = b; r.bvalid = bv; r.freed = fr[12:0];
        r.released = rel; r.last = lst;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_ring(t_req q);
        int s, n, fr, f, p;
        logic [2:0] bitm;
        s = -1;
        if (q.op == mrrb_pkg::OP_CREATE) begin
            wipe_pipe();
            used[0] = 1'b1; owner[0] = q.pid; flags[0] = 3'b011; live_slots = 1;
            push_result(mrrb_pkg::STS_OK, 0, 0, 0, 0, 1);
            return;
        end
        if (q.op == mrrb_pkg::OP_NONE) begin
            push_result(mrrb_pkg::STS_NOTHING, 0, 0, 0, 0, 1);
            return;
        end
        for (int i = SLOTS - 1; i >= 0; i--)
            if (used[i] && owner[i] == q.pid) s = i;
        if (s < 0) begin
            push_result(mrrb_pkg::STS_UNKNOWN, 0, 0, 0, 0, 1);
            return;
        end
        case (q.op)
            mrrb_pkg::OP_WRITE: begin
                if (!flags[s][1]) push_result(mrrb_pkg::STS_CLOSED, 0, 0, 0, 0, 1);
                else if (held >= RING) push_result(mrrb_pkg::STS_NOTHING, 0, 0, 0, 0, 1);
                else begin
                    ring_mem[wr_ptr] = q.wbyte;
                    wr_ptr = (wr_ptr + 1) % RING;
                    held++;
                    for (int i = 0; i < SLOTS; i++) flags[i][2] = 1'b0;
                    push_result(mrrb_pkg::STS_OK, 0, 0, 0, 0, 1);
                end
            end
            mrrb_pkg::OP_READ: begin
                n = unread(s);
                if (!flags[s][0]) push_result(mrrb_pkg::STS_CLOSED, 0, 0, 0, 0, 1);
                else begin
                    if (n > q.cnt) n = q.cnt;
                    if (n > BURST) n = BURST;
                    if (n == 0) push_result(mrrb_pkg::STS_NOTHING, 0, 0, 0, 0, 1);
                    else begin
                        p = rd_ptr[s];
                        for (int k = 0; k < n; k++) begin
                            push_result(mrrb_pkg::STS_OK, ring_mem[p], 1, 0, 0, k + 1 == n);
                            p = (p + 1) % RING;
                        end
                        rd_ptr[s] = p;
                        if (p == wr_ptr) flags[s][2] = 1'b1;
                    end
                end
            end
            mrrb_pkg::OP_FLUSH: begin
                fr = held;
                for (int i = 0; i < SLOTS; i++)
                    if (used[i] && flags[i][0] && held - unread(i) < fr)
                        fr = held - unread(i);
                rc_ptr = (rc_ptr + fr) % RING;
                held -= fr;
                if (fr != 0)
                    for (int i = 0; i < SLOTS; i++) flags[i][2] = 1'b0;
                push_result(mrrb_pkg::STS_OK, 0, 0, fr, 0, 1);
            end
            mrrb_pkg::OP_FORK: begin
                f = -1;
                if (live_slots < SLOTS)
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!used[i]) f = i;
                if (f < 0) push_result(mrrb_pkg::STS_FULL, 0, 0, 0, 0, 1);
                else begin
                    used[f] = 1'b1; owner[f] = q.child;
                    flags[f] = flags[s]; rd_ptr[f] = rd_ptr[s];
                    live_slots++;
                    push_result(mrrb_pkg::STS_OK, 0, 0, 0, 0, 1);
                end
            end
            default: begin
                bitm = (q.op == mrrb_pkg::OP_CLOSE_RD) ? 3'b001 : 3'b010;
                if ((flags[s] & bitm) == 0) push_result(mrrb_pkg::STS_CLOSED, 0, 0, 0, 0, 1);
                else begin
                    flags[s] = flags[s] & ~bitm;
                    if (flags[s][1:0] == 2'b00) begin
                        used[s] = 1'b0; owner[s] = '0; flags[s] = '0; rd_ptr[s] = 0;
                        if (live_slots > 0) live_slots--;
                    end
                    if (live_slots == 0 && !used[s]) begin
                        wipe_pipe();
                        push_result(mrrb_pkg::STS_OK, 0, 0, 0, 1, 1);
                    end else
                        push_result(mrrb_pkg::STS_OK, 0, 0, 0, 0, 1);
                end
            end
        endcase
    endfunction

    task automatic add_req(mrrb_pkg::t_op op, logic [15:0] pid, logic [15:0] child,
                           logic [7:0] wb, logic [6:0] cnt);
        t_req q;
        q.op = op; q.pid = pid; q.child = child; q.wbyte = wb; q.cnt = cnt;
        pending_reqs.push_back(q);
    endtask

    // small pool of owners so that most items find their slot
    function automatic logic [15:0] pick_pid();
        if ($urandom_range(0, 19) == 0) return 16'($urandom);
        return 16'($urandom_range(1, 6));
    endfunction

    // request driver
    always @(posedge i_clk) begin
        t_req q;
        logic idle;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                q.op = mrrb_pkg::t_op'(i_opcode); q.pid = i_process_id;
                q.child = i_child_id; q.wbyte = i_write_byte; q.cnt = i_byte_count;
                predict_ring(q);
                reqs_taken++;
            end
            idle = !(reqs_taken >= 150 && reqs_taken < 300) && $urandom_range(0, 99) < 6;
            if (pending_reqs.size() != 0 && !idle) begin
                q = pending_reqs.pop_front();
                i_valid      <= 1'b1;
                i_opcode     <= q.op;
                i_process_id <= q.pid;
                i_child_id   <= q.child;
                i_write_byte <= q.wbyte;
                i_byte_count <= q.cnt;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result monitor
    int hold_cycles = 0;
    logic hold_done = 1'b0;
    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result item with nothing expected");
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_status); errors++;
                    end
                    if (o_read_byte !== e.rbyte) begin
                        $error("read_byte exp %0h got %0h", e.rbyte, o_read_byte); errors++;
                    end
                    if (o_byte_valid !== e.bvalid) begin
                        $error("byte_valid exp %0b got %0b", e.bvalid, o_byte_valid);
                        errors++;
                    end
                    if (o_reclaimed_count !== e.freed) begin
                        $error("reclaimed_count exp %0d got %0d", e.freed, o_reclaimed_count);
                        errors++;
                    end
                    if (o_pipe_released !== e.released) begin
                        $error("pipe_released exp %0b got %0b", e.released, o_pipe_released);
                        errors++;
                    end
                    if (o_last !== e.last) begin
                        $error("last exp %0b got %0b", e.last, o_last); errors++;
                    end
                end
            end
            // long hold-off once, so the block backs up onto its input
            if (!hold_done && results_seen >= 400) begin
                i_ready <= 1'b0;
                hold_cycles++;
                if (hold_cycles >= 500) hold_done = 1'b1;
            end else begin
                i_ready <= (results_seen >= 100 && results_seen < 350) ||
                           $urandom_range(0, 99) >= 6;
            end
        end
    end

    initial begin
        int r;
        for (int i = 0; i < RING; i++) ring_mem[i] = '0;
        wipe_pipe();

        // directed
        add_req(mrrb_pkg::OP_WRITE, 16'd1, 16'd0, 8'h00, 7'd1);      // before create
        add_req(mrrb_pkg::OP_CREATE, 16'd1, 16'd0, 8'h00, 7'd1);
        add_req(mrrb_pkg::OP_READ, 16'd1, 16'd0, 8'h00, 7'd8);       // nothing to read
        add_req(mrrb_pkg::OP_WRITE, 16'd1, 16'hffff, 8'hff, 7'd0);
        add_req(mrrb_pkg::OP_WRITE, 16'd1, 16'd0, 8'h00, 7'd0);
        add_req(mrrb_pkg::OP_WRITE, 16'd1, 16'd0, 8'h5a, 7'd0);
        add_req(mrrb_pkg::OP_READ, 16'd1, 16'd0, 8'h00, 7'd0);       // zero count
        add_req(mrrb_pkg::OP_READ, 16'd1, 16'd0, 8'h00, 7'd127);
        add_req(mrrb_pkg::OP_FORK, 16'd1, 16'hffff, 8'h00, 7'd0);
        add_req(mrrb_pkg::OP_FORK, 16'd1, 16'hffff, 8'h00, 7'd0);    // duplicate child id
        add_req(mrrb_pkg::OP_WRITE, 16'hffff, 16'd0, 8'h33, 7'd0);
        add_req(mrrb_pkg::OP_FLUSH, 16'd1, 16'd0, 8'h00, 7'd0);
        add_req(mrrb_pkg::OP_READ, 16'hffff, 16'd0, 8'h00, 7'd1);
        add_req(mrrb_pkg::OP_CLOSE_RD, 16'hffff, 16'd0, 8'h00, 7'd0);
        add_req(mrrb_pkg::OP_CLOSE_RD, 16'hffff, 16'd0, 8'h00, 7'd0); // already closed
        add_req(mrrb_pkg::OP_READ, 16'hffff, 16'd0, 8'h00, 7'd1);
        add_req(mrrb_pkg::OP_FLUSH, 16'd1, 16'd0, 8'h00, 7'd0);
        add_req(mrrb_pkg::OP_NONE, 16'd1, 16'd0, 8'h00, 7'd0);
        for (int i = 0; i < 7; i++)                                   // table full
            add_req(mrrb_pkg::OP_FORK, 16'd1, 16'(100 + i), 8'h00, 7'd0);
        add_req(mrrb_pkg::OP_CLOSE_WR, 16'd1, 16'd0, 8'h00, 7'd0);
        add_req(mrrb_pkg::OP_WRITE, 16'd1, 16'd0, 8'h11, 7'd0);

        // two readers on one ring, each reading with a different byte count
        add_req(mrrb_pkg::OP_CREATE, 16'd7, 16'd0, 8'h00, 7'd0);
        add_req(mrrb_pkg::OP_FORK, 16'd7, 16'd8, 8'h00, 7'd0);
        for (int i = 0; i < 24; i++)
            add_req(mrrb_pkg::OP_WRITE, 16'd7, 16'd0, 8'($urandom), 7'd0);
        add_req(mrrb_pkg::OP_WRITE, 16'd7, 16'd0, 8'h77, 7'd0);
        add_req(mrrb_pkg::OP_FLUSH, 16'd7, 16'd0, 8'h00, 7'd0);
        add_req(mrrb_pkg::OP_READ, 16'd7, 16'd0, 8'h00, 7'd64);
        add_req(mrrb_pkg::OP_READ, 16'd8, 16'd0, 8'h00, 7'd100);
        add_req(mrrb_pkg::OP_FLUSH, 16'd8, 16'd0, 8'h00, 7'd0);
        // release the pipe: close every end of both slots
        add_req(mrrb_pkg::OP_CLOSE_RD, 16'd7, 16'd0, 8'h00, 7'd0);
        add_req(mrrb_pkg::OP_CLOSE_WR, 16'd7, 16'd0, 8'h00, 7'd0);
        add_req(mrrb_pkg::OP_CLOSE_RD, 16'd8, 16'd0, 8'h00, 7'd0);
        add_req(mrrb_pkg::OP_CLOSE_WR, 16'd8, 16'd0, 8'h00, 7'd0);

        // random, mostly well-formed traffic on a small set of owners
        add_req(mrrb_pkg::OP_CREATE, 16'd1, 16'd0, 8'h00, 7'd0);
        for (int i = 0; i < 425; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                add_req(mrrb_pkg::OP_CREATE, pick_pid(), 16'($urandom), 8'($urandom),
                        7'($urandom));
            else if (r < 45)
                add_req(mrrb_pkg::OP_WRITE, pick_pid(), 16'($urandom), 8'($urandom),
                        7'($urandom));
            else if (r < 70)
                add_req(mrrb_pkg::OP_READ, pick_pid(), 16'($urandom),
                        8'($urandom), ($urandom_range(0, 9) == 0) ? 7'($urandom)
                                                                : 7'($urandom_range(1, 12)));
            else if (r < 80)
                add_req(mrrb_pkg::OP_FLUSH, pick_pid(), 16'($urandom), 8'($urandom),
                        7'($urandom));
            else if (r < 90)
                add_req(mrrb_pkg::OP_FORK, pick_pid(), pick_pid(), 8'($urandom),
                        7'($urandom));
            else if (r < 94)
                add_req(mrrb_pkg::OP_CLOSE_RD, pick_pid(), 16'($urandom), 8'($urandom),
                        7'($urandom));
            else if (r < 98)
                add_req(mrrb_pkg::OP_CLOSE_WR, pick_pid(), 16'($urandom), 8'($urandom),
                        7'($urandom));
            else
                add_req(mrrb_pkg::OP_NONE, pick_pid(), 16'($urandom), 8'($urandom),
                        7'($urandom));
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !i_valid && expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #100ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
